// ===== src/u8d_pkg.sv =====
// Shared types, constants and a helper function for the UTF-8 decoder.
package u8d_pkg;

  // Default number of entries in the command queue between front and back.
  localparam int unsigned U8D_QUEUE_DEPTH = 4;

  localparam int unsigned CP_W = 21;
  localparam int unsigned REP_CNT_W = 3;

  localparam logic [CP_W-1:0] REPL_CHAR   = 21'd63;
  localparam logic [CP_W-1:0] MIN_CP_2B   = 21'h00080;
  localparam logic [CP_W-1:0] MIN_CP_3B   = 21'h00800;
  localparam logic [CP_W-1:0] MIN_CP_4B   = 21'h10000;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h0DFFF;
  localparam logic [CP_W-1:0] MAX_CP      = 21'h10FFFF;

  // Number of continuation bytes a lead byte asks for.
  localparam logic [1:0] NEED_NONE = 2'd0;
  localparam logic [1:0] NEED_ONE  = 2'd1;
  localparam logic [1:0] NEED_TWO  = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // One queue entry: a run of replacement results, then an optional tail result.
  typedef struct packed {
    logic [REP_CNT_W-1:0] rep_count;
    logic                 has_tail;
    logic [CP_W-1:0]      tail_cp;
    logic                 tail_rep;
    logic                 tail_eot;
  } cmd_t;

  function automatic logic [1:0] needed(input logic [7:0] lead);
    logic [1:0] n;
    n = NEED_NONE;
    if ((lead & 8'he0) == 8'hc0) n = NEED_ONE;
    else if ((lead & 8'hf0) == 8'he0) n = NEED_TWO;
    else if ((lead & 8'hf8) == 8'hf0) n = NEED_THREE;
    return n;
  endfunction

endpackage

// ===== src/u8d_front.sv =====
// Front end: takes text bytes, tracks the pending sequence and issues commands.
module u8d_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          q_full,
  output logic          q_push,
  output u8d_pkg::cmd_t q_cmd
);
  import u8d_pkg::*;

  logic [7:0]  held_lead_r, held_lead_nxt;
  logic [17:0] held_payload_r, held_payload_nxt;
  logic [1:0]  held_count_r, held_count_nxt;
  logic        pending_r, pending_nxt;

  logic        accepted;
  logic [1:0]  need;
  logic [1:0]  need_b;
  logic        is_cont;
  logic [2:0]  cnt;
  logic [17:0] payload_n;
  logic [CP_W-1:0] cp;
  logic        ok;
  logic        idle_path;
  cmd_t        cmd;

  assign in_tready = !q_full;
  assign accepted  = in_tvalid && in_tready;
  assign need      = needed(held_lead_r);
  assign need_b    = needed(in_tdata);
  assign is_cont   = (in_tdata[7:6] == 2'b10);
  assign cnt       = {1'b0, held_count_r} + 3'd1;
  assign payload_n = {held_payload_r[11:0], in_tdata[5:0]};

  // Assemble the completed code point and check it for the lead's length.
  always_comb begin
    cp = '0;
    ok = 1'b0;
    unique case (need)
      NEED_ONE: begin
        cp = {10'b0, held_lead_r[4:0], 6'b0} | {3'b0, payload_n};
        ok = cp >= MIN_CP_2B;
      end
      NEED_TWO: begin
        cp = {5'b0, held_lead_r[3:0], 12'b0} | {3'b0, payload_n};
        ok = (cp >= MIN_CP_3B) && ((cp < SURR_LO) || (cp > SURR_HI));
      end
      NEED_THREE: begin
        cp = {held_lead_r[2:0], payload_n};
        ok = (cp >= MIN_CP_4B) && (cp <= MAX_CP);
      end
      default: begin
        cp = '0;
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd              = '0;
    idle_path        = 1'b0;
    held_lead_nxt    = held_lead_r;
    held_payload_nxt = held_payload_r;
    held_count_nxt   = held_count_r;
    pending_nxt      = pending_r;
    if (pending_r) begin
      if (is_cont && (need != NEED_NONE)) begin
        if (cnt >= {1'b0, need}) begin
          if (ok) begin
            cmd.has_tail = 1'b1;
            cmd.tail_cp  = cp;
          end else begin
            cmd.rep_count = {1'b0, need} + 3'd1;
          end
          held_lead_nxt    = '0;
          held_payload_nxt = '0;
          held_count_nxt   = '0;
          pending_nxt      = 1'b0;
        end else begin
          held_payload_nxt = payload_n;
          held_count_nxt   = cnt[1:0];
        end
      end else begin
        // Interrupted sequence: one replacement per held byte, then decode afresh.
        cmd.rep_count    = cnt;
        held_lead_nxt    = '0;
        held_payload_nxt = '0;
        held_count_nxt   = '0;
        pending_nxt      = 1'b0;
        idle_path        = 1'b1;
      end
    end else begin
      idle_path = 1'b1;
    end

    if (idle_path) begin
      if (in_tdata == 8'h00) begin
        cmd.has_tail = 1'b1;
        cmd.tail_eot = 1'b1;
      end else if (!in_tdata[7]) begin
        cmd.has_tail = 1'b1;
        cmd.tail_cp  = {13'b0, in_tdata};
      end else if (need_b != NEED_NONE) begin
        held_lead_nxt    = in_tdata;
        held_payload_nxt = '0;
        held_count_nxt   = '0;
        pending_nxt      = 1'b1;
      end else begin
        cmd.has_tail = 1'b1;
        cmd.tail_cp  = REPL_CHAR;
        cmd.tail_rep = 1'b1;
      end
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accepted && (cmd.has_tail || (cmd.rep_count != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lead_r    <= '0;
      held_payload_r <= '0;
      held_count_r   <= '0;
      pending_r      <= 1'b0;
    end else if (accepted) begin
      held_lead_r    <= held_lead_nxt;
      held_payload_r <= held_payload_nxt;
      held_count_r   <= held_count_nxt;
      pending_r      <= pending_nxt;
    end
  end

endmodule

// ===== src/u8d_queue.sv =====
// Small command queue between the front end and the result expander.
module u8d_queue #(
  parameter int unsigned DEPTH = u8d_pkg::U8D_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u8d_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output u8d_pkg::cmd_t head_cmd
);
  import u8d_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_cmd  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count above depth");
  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("command pushed into a full queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count did not follow a push");

endmodule

// ===== src/u8d_back.sv =====
// Back end: expands queued commands into result items behind an output register.
module u8d_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  u8d_pkg::cmd_t              q_head,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [u8d_pkg::CP_W-1:0]   out_code_point,
  output logic                       out_replaced,
  output logic                       out_eot,
  output logic                       out_last
);
  import u8d_pkg::*;

  logic [REP_CNT_W-1:0] rep_done_r, rep_done_nxt;
  logic                 out_tvalid_r;
  logic [CP_W-1:0]      cp_r;
  logic                 rep_r, eot_r, last_r;
  logic                 load;
  logic                 in_reps;
  logic [CP_W-1:0]      cp_nxt;
  logic                 rep_nxt, eot_nxt, last_nxt;

  assign load    = q_not_empty && (!out_tvalid_r || out_tready);
  assign in_reps = rep_done_r < q_head.rep_count;

  always_comb begin
    if (in_reps) begin
      cp_nxt   = REPL_CHAR;
      rep_nxt  = 1'b1;
      eot_nxt  = 1'b0;
      last_nxt = ((rep_done_r + REP_CNT_W'(1)) == q_head.rep_count) && !q_head.has_tail;
    end else begin
      cp_nxt   = q_head.tail_cp;
      rep_nxt  = q_head.tail_rep;
      eot_nxt  = q_head.tail_eot;
      last_nxt = 1'b1;
    end
    rep_done_nxt = rep_done_r;
    if (load) rep_done_nxt = last_nxt ? '0 : rep_done_r + REP_CNT_W'(1);
  end

  assign q_pop = load && last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      rep_done_r   <= '0;
    end else begin
      rep_done_r <= rep_done_nxt;
      if (load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= cp_nxt;
      rep_r  <= rep_nxt;
      eot_r  <= eot_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid     = out_tvalid_r;
  assign out_code_point = cp_r;
  assign out_replaced   = rep_r;
  assign out_eot        = eot_r;
  assign out_last       = last_r;

endmodule

// ===== src/utf8_decoder_with_replacement_top.sv =====
// Top level of the UTF-8 decoder with replacement characters.
//
// Usage: text bytes enter on the in_ stream, one byte per item; a zero byte
// ends the text. Decoded code points leave on the out_ stream. Each out item
// carries the code point in tdata, a replacement flag and an end-of-text flag
// in tuser, and tlast marks the final result caused by one input byte.
// A byte that only extends a pending multi-byte sequence yields no result; an
// invalid or interrupted sequence yields one '?' per byte it held.
// When the output is free, the edge that accepts a byte writes its command
// into the command queue, and the result then moves into the output register.
// Throughput: one byte per cycle while every byte yields at most one result;
// the result side emits one item per cycle while out_tready is high, so a
// byte that causes a burst of up to four results is emitted item by item,
// absorbed by the command queue between the decode front end and the result
// expander. Input stalls only when that queue is full.
// Reset (rst_n low, synchronous) drops any pending sequence and empties the
// queue and output register. When the receiver holds out_tready low, the
// output register keeps its item and the front keeps taking bytes until the
// queue fills.
module utf8_decoder_with_replacement_top #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::U8D_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [1:0]  out_tuser,  // [0] replaced, [1] end_of_text
  output logic        out_tlast
);
  import u8d_pkg::*;

  cmd_t            push_cmd, head_cmd;
  logic            push, pop, full, not_empty;
  logic [CP_W-1:0] code_point;
  logic            replaced, eot;

  // Front end: classifies each byte against the pending sequence.
  u8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  // Queue lets the front keep accepting while the back drains a burst.
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_cmd  (head_cmd)
  );

  // Back end: one result item per cycle from the head command while out_tready is high.
  u8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (not_empty),
    .q_head         (head_cmd),
    .q_pop          (pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_code_point (code_point),
    .out_replaced   (replaced),
    .out_eot        (eot),
    .out_last       (out_tlast)
  );

  assign out_tdata = {3'b000, code_point};
  assign out_tuser = {eot, replaced};

endmodule
